FILE: rtl/kphd_pkg.sv
// ----------------------------------------------------------------------------
// kphd_pkg
// Shared types and constants of the key press / hold / double press classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package kphd_pkg;

  localparam int KPHD_NUM_KEYS = 128;

  localparam int KEY_W   = 7;
  localparam int ACT_W   = 2;
  localparam int TIME_W  = 32;
  localparam int FLAG_W  = 4;
  localparam int CFG_W   = 16;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [ACT_W-1:0] ACT_NONE    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_PRESS   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;

  localparam logic [FLAG_W-1:0] FLAG_NONE    = 4'b0000;
  localparam logic [FLAG_W-1:0] FLAG_PRESS   = 4'b0001;
  localparam logic [FLAG_W-1:0] FLAG_HOLD    = 4'b0010;
  localparam logic [FLAG_W-1:0] FLAG_RELEASE = 4'b0100;
  localparam logic [FLAG_W-1:0] FLAG_DOUBLE  = 4'b1000;

  localparam logic [1:0] REG_RELEASE_MIN = 2'd0;
  localparam logic [1:0] REG_DOUBLE_MIN  = 2'd1;
  localparam logic [1:0] REG_DOUBLE_MAX  = 2'd2;
  localparam logic [1:0] REG_HOLD_MAX    = 2'd3;

  localparam logic [CFG_W-1:0] RELEASE_MIN_RST = 16'd20;
  localparam logic [CFG_W-1:0] DOUBLE_MIN_RST  = 16'd50;
  localparam logic [CFG_W-1:0] DOUBLE_MAX_RST  = 16'd300;
  localparam logic [CFG_W-1:0] HOLD_MAX_RST    = 16'd100;

  typedef struct packed {
    logic [CFG_W-1:0] release_min;
    logic [CFG_W-1:0] double_min;
    logic [CFG_W-1:0] double_max;
    logic [CFG_W-1:0] hold_max;
  } cfg_t;

  typedef struct packed {
    logic [FLAG_W-1:0] flags;
    logic [FLAG_W-1:0] last_sig;
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] dur;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic read;
    logic elapse;
    logic decide;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/kphd_cfg.sv
// ----------------------------------------------------------------------------
// kphd_cfg
// Threshold registers behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module kphd_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [kphd_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [kphd_pkg::PDATA_W-1:0]   pwdata,
  output logic      [kphd_pkg::PDATA_W-1:0]   prdata,
  output logic                                pready,
  output kphd_pkg::cfg_t                      cfg
);
  import kphd_pkg::*;

  logic [CFG_W-1:0] release_min_r;
  logic [CFG_W-1:0] double_min_r;
  logic [CFG_W-1:0] double_max_r;
  logic [CFG_W-1:0] hold_max_r;
  logic             wr_en;
  logic [1:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      release_min_r <= RELEASE_MIN_RST;
      double_min_r  <= DOUBLE_MIN_RST;
      double_max_r  <= DOUBLE_MAX_RST;
      hold_max_r    <= HOLD_MAX_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_RELEASE_MIN: release_min_r <= pwdata[CFG_W-1:0];
        REG_DOUBLE_MIN:  double_min_r  <= pwdata[CFG_W-1:0];
        REG_DOUBLE_MAX:  double_max_r  <= pwdata[CFG_W-1:0];
        REG_HOLD_MAX:    hold_max_r    <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RELEASE_MIN: prdata = PDATA_W'(release_min_r);
      REG_DOUBLE_MIN:  prdata = PDATA_W'(double_min_r);
      REG_DOUBLE_MAX:  prdata = PDATA_W'(double_max_r);
      REG_HOLD_MAX:    prdata = PDATA_W'(hold_max_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg.release_min = release_min_r;
  assign cfg.double_min  = double_min_r;
  assign cfg.double_max  = double_max_r;
  assign cfg.hold_max    = hold_max_r;

endmodule

`default_nettype wire

FILE: rtl/kphd_ctrl.sv
// ----------------------------------------------------------------------------
// kphd_ctrl
// Sequencer: table clearing after reset, then read, elapse, decide per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module kphd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire kphd_pkg::dp_stat_t   stat,
  output kphd_pkg::ctrl_cmd_t       cmd
);
  import kphd_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_ELAPSE = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_ELAPSE;
      end
      ST_ELAPSE: begin
        cmd.elapse = 1'b1;
        state_nxt  = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/kphd_dpath.sv
// ----------------------------------------------------------------------------
// kphd_dpath
// Per-key table, elapsed time and classification, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module kphd_dpath #(
  parameter int NUM_KEYS = kphd_pkg::KPHD_NUM_KEYS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire kphd_pkg::ctrl_cmd_t           cmd,
  output kphd_pkg::dp_stat_t                 stat,
  input  wire kphd_pkg::cfg_t                cfg,
  input  wire logic [kphd_pkg::KEY_W-1:0]    in_key_index,
  input  wire logic [kphd_pkg::ACT_W-1:0]    in_action,
  input  wire logic [kphd_pkg::TIME_W-1:0]   in_now_ms,
  output logic                               out_strobe,
  output logic      [kphd_pkg::KEY_W-1:0]    out_key_out,
  output logic      [kphd_pkg::FLAG_W-1:0]   out_flags,
  output logic                               out_updated,
  output logic      [kphd_pkg::TIME_W-1:0]   out_held_ms
);
  import kphd_pkg::*;

  localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int XW = (AW > KEY_W) ? AW : KEY_W;

  entry_t            mem [NUM_KEYS];
  entry_t            rd_r;
  entry_t            ent_nxt;
  logic [AW-1:0]     clr_cnt_r;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     addr;
  logic [XW-1:0]     key_ext;
  logic              key_ok;
  logic              mem_we;
  logic [KEY_W-1:0]  key_r;
  logic [ACT_W-1:0]  action_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] elapsed_r;
  logic              down;
  logic              is_double;
  logic              changed;
  logic              strobe_r;
  logic [FLAG_W-1:0] flags_r;
  logic              updated_r;
  logic [TIME_W-1:0] held_r;

  assign key_ext = XW'(key_r);
  assign addr    = key_ext[AW-1:0];
  assign key_ok  = (32'(key_r) < NUM_KEYS);
  assign mem_we  = cmd.clear || (cmd.decide && key_ok);
  assign wr_addr = cmd.clear ? clr_cnt_r : addr;

  assign stat.clear_last = (clr_cnt_r == AW'(NUM_KEYS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // key table
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= cmd.clear ? '0 : ent_nxt;
    if (cmd.read && key_ok) rd_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r    <= in_key_index;
      action_r <= in_action;
      now_r    <= in_now_ms;
    end
    if (cmd.elapse) elapsed_r <= now_r - rd_r.stamp;
  end

  always_comb begin
    down      = rd_r.flags[0] || rd_r.flags[1];
    is_double = rd_r.last_sig[2] && (elapsed_r > TIME_W'(cfg.double_min))
                && (elapsed_r < TIME_W'(cfg.double_max));
    ent_nxt   = rd_r;
    case (action_r)
      ACT_RELEASE: begin
        if (elapsed_r >= TIME_W'(cfg.release_min)) begin
          if (down) begin
            ent_nxt.flags    = FLAG_RELEASE;
            ent_nxt.last_sig = FLAG_RELEASE;
            ent_nxt.stamp    = now_r;
            ent_nxt.dur      = '0;
          end else begin
            ent_nxt.flags = FLAG_NONE;
          end
        end
      end
      ACT_PRESS: begin
        ent_nxt.stamp = now_r;
        if (is_double) begin
          ent_nxt.flags    = FLAG_PRESS | FLAG_DOUBLE;
          ent_nxt.last_sig = FLAG_PRESS | FLAG_DOUBLE;
          ent_nxt.dur      = elapsed_r;
        end else if (down && (elapsed_r < TIME_W'(cfg.hold_max))) begin
          ent_nxt.flags    = FLAG_HOLD;
          ent_nxt.last_sig = FLAG_HOLD;
          ent_nxt.dur      = rd_r.dur + elapsed_r;
        end else begin
          ent_nxt.flags    = FLAG_PRESS;
          ent_nxt.last_sig = FLAG_PRESS;
          ent_nxt.dur      = '0;
        end
      end
      default: ;
    endcase
    changed = (ent_nxt != rd_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.decide;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      flags_r   <= key_ok ? ent_nxt.flags : FLAG_NONE;
      updated_r <= key_ok && changed;
      held_r    <= key_ok ? ent_nxt.dur : '0;
    end
  end

  assign out_strobe  = strobe_r;
  assign out_key_out = key_r;
  assign out_flags   = flags_r;
  assign out_updated = updated_r;
  assign out_held_ms = held_r;

endmodule

`default_nettype wire

FILE: rtl/key_press_hold_double_classifier.sv
// ----------------------------------------------------------------------------
// key_press_hold_double_classifier
// Classifies key poll samples into press, hold, release and double press.
// ----------------------------------------------------------------------------
// A sample is taken when start is high and busy is low; its result appears on
// the out_ ports for one cycle with out_strobe after a registered read, an
// elapsed time stage, then the decision and write-back in the single per-key
// table, and busy is low again in that same cycle, so no new sample is taken
// before the last one's result. After reset busy stays high while all NUM_KEYS
// table entries are cleared one entry a cycle. Results cannot be stalled.
// Thresholds are written over the APB-style port.
`default_nettype none

module key_press_hold_double_classifier #(
  parameter int NUM_KEYS = kphd_pkg::KPHD_NUM_KEYS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [kphd_pkg::KEY_W-1:0]    in_key_index,
  input  wire logic [kphd_pkg::ACT_W-1:0]    in_action,
  input  wire logic [kphd_pkg::TIME_W-1:0]   in_now_ms,
  output logic                               out_strobe,
  output logic      [kphd_pkg::KEY_W-1:0]    out_key_out,
  output logic      [kphd_pkg::FLAG_W-1:0]   out_flags,
  output logic                               out_updated,
  output logic      [kphd_pkg::TIME_W-1:0]   out_held_ms,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [kphd_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [kphd_pkg::PDATA_W-1:0]  pwdata,
  output logic      [kphd_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);
  import kphd_pkg::*;

  cfg_t      cfg;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  kphd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kphd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  kphd_dpath #(
    .NUM_KEYS (NUM_KEYS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .cfg          (cfg),
    .in_key_index (in_key_index),
    .in_action    (in_action),
    .in_now_ms    (in_now_ms),
    .out_strobe   (out_strobe),
    .out_key_out  (out_key_out),
    .out_flags    (out_flags),
    .out_updated  (out_updated),
    .out_held_ms  (out_held_ms)
  );

  a_beat_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##3 out_strobe)
    else $error("result beat missing after accepted sample");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result beat while sequencer busy");

  a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (32'(out_key_out) >= NUM_KEYS)) |->
      (out_flags == FLAG_NONE && !out_updated && out_held_ms == '0))
    else $error("out of range key gave a non-empty result");

  a_double_press: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_flags[3]) |-> out_flags[0])
    else $error("double press without press flag");

endmodule

`default_nettype wire

FILE: verif/key_press_hold_double_classifier_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_press_hold_double_classifier_tb
// Self-checking bench for the key press / hold / double press classifier.
// A short table of directed key samples is run first. Random sample streams
// follow under several threshold settings and sender idle rates. Every
// result beat is compared with its expected report: the row's own result for
// typed directed rows, else a per-key behavioural model kept in the bench.
// ----------------------------------------------------------------------------
module key_press_hold_double_classifier_tb;
  import kphd_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED   = 2'd3;
  localparam int               CYCLE_LIMIT  = 400000;
  localparam int               DRAIN_CYCLES = 8;
  localparam int               NUM_ROWS     = 25;
  localparam int               PHASE_ITEMS  = 305;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [FLAG_W-1:0] flags;
    logic              updated;
    logic [TIME_W-1:0] held;
  } key_report_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ACT_W-1:0]  action;
    logic [TIME_W-1:0] now;
    logic              typed;
    key_report_t       report;
  } sample_row_t;

  // typed rows carry their own result; the rest are left to the key model
  localparam sample_row_t DIRECTED [NUM_ROWS] = '{
    '{7'd0,   ACT_NONE,    32'd0,         1'b1, '{7'd0,   FLAG_NONE,  1'b0, 32'd0}},
    '{7'd127, ACT_RELEASE, 32'd5,         1'b1, '{7'd127, FLAG_NONE,  1'b0, 32'd0}},
    '{7'd127, ACT_RELEASE, 32'hFFFF_FFFF, 1'b1, '{7'd127, FLAG_NONE,  1'b0, 32'd0}},
    '{7'd1,   ACT_PRESS,   32'd1000,      1'b1, '{7'd1,   FLAG_PRESS, 1'b1, 32'd0}},
    '{7'd1,   ACT_PRESS,   32'd1050,      1'b0, '0},
    '{7'd1,   ACT_PRESS,   32'd1149,      1'b0, '0},
    '{7'd1,   ACT_PRESS,   32'd1249,      1'b0, '0},
    '{7'd1,   ACT_RELEASE, 32'd1260,      1'b0, '0},
    '{7'd1,   ACT_RELEASE, 32'd1269,      1'b0, '0},
    '{7'd1,   ACT_PRESS,   32'd1319,      1'b0, '0},
    '{7'd1,   ACT_RELEASE, 32'd1339,      1'b0, '0},
    '{7'd1,   ACT_PRESS,   32'd1390,      1'b0, '0},
    '{7'd1,   ACT_RELEASE, 32'd1410,      1'b0, '0},
    '{7'd1,   ACT_PRESS,   32'd1709,      1'b0, '0},
    '{7'd1,   ACT_RELEASE, 32'd1729,      1'b0, '0},
    '{7'd1,   ACT_PRESS,   32'd2029,      1'b0, '0},
    '{7'd1,   ACT_RELEASE, 32'd2049,      1'b0, '0},
    '{7'd1,   ACT_RELEASE, 32'd2100,      1'b0, '0},
    '{7'd1,   ACT_PRESS,   32'd2250,      1'b0, '0},
    '{7'd2,   ACT_UNUSED,  32'hFFFF_FFFF, 1'b1, '{7'd2,   FLAG_NONE,  1'b0, 32'd0}},
    '{7'd2,   ACT_PRESS,   32'hFFFF_FFF0, 1'b0, '0},
    '{7'd2,   ACT_PRESS,   32'h0000_0010, 1'b0, '0},
    '{7'd2,   ACT_RELEASE, 32'h0000_0030, 1'b0, '0},
    '{7'd2,   ACT_PRESS,   32'h0000_0070, 1'b0, '0},
    '{7'd85,  ACT_PRESS,   32'h5555_5555, 1'b0, '0}
  };

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [KEY_W-1:0]    in_key_index;
  logic [ACT_W-1:0]    in_action;
  logic [TIME_W-1:0]   in_now_ms;
  logic                out_strobe;
  logic [KEY_W-1:0]    out_key_out;
  logic [FLAG_W-1:0]   out_flags;
  logic                out_updated;
  logic [TIME_W-1:0]   out_held_ms;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // per-key model state and thresholds
  logic [FLAG_W-1:0] key_flags [KPHD_NUM_KEYS];
  logic [FLAG_W-1:0] key_last_sig [KPHD_NUM_KEYS];
  logic [TIME_W-1:0] key_stamp [KPHD_NUM_KEYS];
  logic [TIME_W-1:0] key_held [KPHD_NUM_KEYS];
  logic [CFG_W-1:0]  thr_release_min;
  logic [CFG_W-1:0]  thr_double_min;
  logic [CFG_W-1:0]  thr_double_max;
  logic [CFG_W-1:0]  thr_hold_max;

  key_report_t       pending_reports [$];
  logic [TIME_W-1:0] clock_ms;
  int                mismatch_count;
  int                cycle_count;

  key_press_hold_double_classifier u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_key_index (in_key_index),
    .in_action    (in_action),
    .in_now_ms    (in_now_ms),
    .out_strobe   (out_strobe),
    .out_key_out  (out_key_out),
    .out_flags    (out_flags),
    .out_updated  (out_updated),
    .out_held_ms  (out_held_ms),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic key_report_t classify_sample(logic [KEY_W-1:0] key,
      logic [ACT_W-1:0] action, logic [TIME_W-1:0] now);
    logic [FLAG_W-1:0] nf;
    logic [FLAG_W-1:0] nls;
    logic [TIME_W-1:0] nst;
    logic [TIME_W-1:0] ndu;
    logic [TIME_W-1:0] elapsed;
    logic              down;
    key_report_t       rep;
    nf      = key_flags[key];
    nls     = key_last_sig[key];
    nst     = key_stamp[key];
    ndu     = key_held[key];
    elapsed = now - key_stamp[key];
    down    = (key_flags[key] & (FLAG_PRESS | FLAG_HOLD)) != FLAG_NONE;
    if (action == ACT_RELEASE) begin
      if (elapsed >= thr_release_min) begin
        if (down) begin
          nf  = FLAG_RELEASE;
          nls = FLAG_RELEASE;
          nst = now;
          ndu = '0;
        end else begin
          nf = FLAG_NONE;
        end
      end
    end else if (action == ACT_PRESS) begin
      if ((key_last_sig[key] & FLAG_RELEASE) != FLAG_NONE &&
          elapsed > thr_double_min && elapsed < thr_double_max) begin
        nf  = FLAG_PRESS | FLAG_DOUBLE;
        nls = FLAG_PRESS | FLAG_DOUBLE;
        nst = now;
        ndu = elapsed;
      end else if (down && elapsed < thr_hold_max) begin
        nf  = FLAG_HOLD;
        nls = FLAG_HOLD;
        nst = now;
        ndu = key_held[key] + elapsed;
      end else begin
        nf  = FLAG_PRESS;
        nls = FLAG_PRESS;
        nst = now;
        ndu = '0;
      end
    end
    rep.key     = key;
    rep.flags   = nf;
    rep.updated = (nf != key_flags[key]) || (nls != key_last_sig[key]) ||
                  (nst != key_stamp[key]) || (ndu != key_held[key]);
    rep.held    = ndu;
    key_flags[key]    = nf;
    key_last_sig[key] = nls;
    key_stamp[key]    = nst;
    key_held[key]     = ndu;
    return rep;
  endfunction

  task automatic issue_sample(logic [KEY_W-1:0] key, logic [ACT_W-1:0] action,
      logic [TIME_W-1:0] now, logic use_typed, key_report_t typed_rep);
    key_report_t rep;
    in_key_index <= key;
    in_action    <= action;
    in_now_ms    <= now;
    start        <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    rep = classify_sample(key, action, now);
    pending_reports.push_back(use_typed ? typed_rep : rep);
  endtask

  task automatic idle_gap(int pct);
    while ($urandom_range(99, 0) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  task automatic write_threshold(logic [1:0] idx, logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_RELEASE_MIN: thr_release_min = value;
      REG_DOUBLE_MIN:  thr_double_min  = value;
      REG_DOUBLE_MAX:  thr_double_max  = value;
      REG_HOLD_MAX:    thr_hold_max    = value;
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_thresholds(logic [CFG_W-1:0] rel_min, logic [CFG_W-1:0] dbl_min,
      logic [CFG_W-1:0] dbl_max, logic [CFG_W-1:0] hold_max);
    drain_results();
    write_threshold(REG_RELEASE_MIN, rel_min);
    write_threshold(REG_DOUBLE_MIN, dbl_min);
    write_threshold(REG_DOUBLE_MAX, dbl_max);
    write_threshold(REG_HOLD_MAX, hold_max);
  endtask

  // mostly a few keys on a slowly advancing clock, so sequences build up
  task automatic run_random(int count, int idle_pct, int span);
    logic [KEY_W-1:0] key;
    logic [ACT_W-1:0] action;
    int               pick;
    for (int n = 0; n < count; n++) begin
      idle_gap(idle_pct);
      if ($urandom_range(199, 0) == 0) drain_results();
      key  = ($urandom_range(3, 0) != 0) ? KEY_W'($urandom_range(3, 0))
                                         : KEY_W'($urandom_range(127, 0));
      pick = $urandom_range(99, 0);
      if (pick < 45)      action = ACT_PRESS;
      else if (pick < 85) action = ACT_RELEASE;
      else if (pick < 95) action = ACT_NONE;
      else                action = ACT_UNUSED;
      pick = $urandom_range(99, 0);
      if (pick < 88)      clock_ms = clock_ms + $urandom_range(span, 0);
      else if (pick < 94) clock_ms = $urandom();
      else                clock_ms = clock_ms - $urandom_range(span, 0);
      issue_sample(key, action, clock_ms, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    key_report_t got;
    key_report_t want;
    if (rst_n && out_strobe) begin
      got = '{out_key_out, out_flags, out_updated, out_held_ms};
      if (pending_reports.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10)
          $display("unexpected result beat: key %0d flags %b updated %b held %0d",
                   got.key, got.flags, got.updated, got.held);
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("result beat differs: key %0d/%0d flags %b/%b updated %b/%b held %0d/%0d",
                     want.key, got.key, want.flags, got.flags,
                     want.updated, got.updated, want.held, got.held);
        end
      end
    end
  end

  initial begin
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_key_index <= '0;
    in_action    <= ACT_NONE;
    in_now_ms    <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    cycle_count  <= 0;
    mismatch_count  = 0;
    clock_ms        = '0;
    thr_release_min = RELEASE_MIN_RST;
    thr_double_min  = DOUBLE_MIN_RST;
    thr_double_max  = DOUBLE_MAX_RST;
    thr_hold_max    = HOLD_MAX_RST;
    for (int k = 0; k < KPHD_NUM_KEYS; k++) begin
      key_flags[k]    = FLAG_NONE;
      key_last_sig[k] = FLAG_NONE;
      key_stamp[k]    = '0;
      key_held[k]     = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < NUM_ROWS; r++)
      issue_sample(DIRECTED[r].key, DIRECTED[r].action, DIRECTED[r].now,
                   DIRECTED[r].typed, DIRECTED[r].report);
    drain_results();

    run_random(PHASE_ITEMS, 0, 400);
    set_thresholds(16'd0, 16'd0, 16'd0, 16'd0);
    run_random(PHASE_ITEMS, 76, 8);
    set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(PHASE_ITEMS, 19, 140000);
    set_thresholds(16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    run_random(PHASE_ITEMS, 0, 70000);
    set_thresholds(CFG_W'($urandom_range(1000, 0)), CFG_W'($urandom_range(1000, 0)),
                   CFG_W'($urandom_range(1000, 0)), CFG_W'($urandom_range(1000, 0)));
    run_random(PHASE_ITEMS, 76, 1200);
    set_thresholds(RELEASE_MIN_RST, DOUBLE_MIN_RST, DOUBLE_MAX_RST, HOLD_MAX_RST);
    run_random(PHASE_ITEMS, 19, 400);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
